FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the pole detector.
// Compiled away when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rstn, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

FILE: rtl/lpd_pkg.sv
// Package of the pole detector: field widths, register indexes, reset values.
// Used by lpd_isqrt and lidar_pole_detector_top.
package lpd_pkg;
    localparam int PoleCount   = 2;
    localparam int SqrtInW     = 34;
    localparam int SqrtOutW    = 17;
    localparam int CfgAddrW    = 3;
    localparam int CfgDataW    = 24;

    typedef enum logic [CfgAddrW-1:0] {
        REG_MIN_RANGE    = 3'd0,
        REG_GAP_SQ       = 3'd1,
        REG_POLE_WIDTH   = 3'd2,
        REG_WIDTH_ERR_SQ = 3'd3,
        REG_EXTENT_X     = 3'd4,
        REG_EXTENT_Y     = 3'd5,
        REG_SENSOR_X     = 3'd6,
        REG_SENSOR_Y     = 3'd7
    } cfg_reg_t;

    localparam logic [14:0] MinRangeReset  = 15'd819;
    localparam logic [23:0] GapSqReset     = 24'd94249;
    localparam logic [11:0] PoleWidthReset = 12'd102;
    localparam logic [23:0] WidthErrReset  = 24'd10404;
    localparam logic [15:0] ExtentReset    = 16'hFFFF;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } sqrt_ctl_t;
endpackage

FILE: rtl/lpd_isqrt.sv
// Iterative integer square root, two radicand bits per cycle.
// Depends on lpd_pkg and assert_macros.svh.
`include "assert_macros.svh"
module lpd_isqrt
    import lpd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [SqrtInW-1:0]  radicand,
    output sqrt_ctl_t           ctl,
    output logic [SqrtOutW-1:0] root
);
    localparam int StepW = $clog2(SqrtOutW + 1);

    logic [SqrtInW-1:0]  rem_reg, rem_next;
    logic [SqrtInW-1:0]  val_reg, val_next;
    logic [SqrtOutW-1:0] root_reg, root_next;
    logic [StepW-1:0]    step_reg, step_next;
    logic                busy_reg, busy_next, done_reg, done_next;
    logic [SqrtOutW+1:0] trial;
    logic [SqrtOutW+1:0] rem_top;

    // Classic restoring digit-by-digit root: bring down two bits, try 4r+1.
    always_comb begin
        rem_top   = {rem_reg[SqrtOutW-1:0], val_reg[SqrtInW-1 -: 2]};
        trial     = {root_reg, 2'b01};
        rem_next  = rem_reg;
        val_next  = val_reg;
        root_next = root_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            val_next  = radicand;
            root_next = '0;
            step_next = StepW'(SqrtOutW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            val_next = {val_reg[SqrtInW-3:0], 2'b00};
            if (rem_top >= trial) begin
                rem_next  = SqrtInW'(rem_top - trial);
                root_next = {root_reg[SqrtOutW-2:0], 1'b1};
            end else begin
                rem_next  = SqrtInW'(rem_top);
                root_next = {root_reg[SqrtOutW-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == StepW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        rem_reg  <= rem_next;
        val_reg  <= val_next;
        root_reg <= root_next;
    end

    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;
    assign root      = root_reg;

    `ASSERT_CLK(a_done_after_busy, aclk, aresetn, done_reg |-> $past(busy_reg))
    `ASSERT_CLK(a_no_start_busy, aclk, aresetn, busy_reg |-> !done_reg)
    `ASSERT_CLK(a_start_busy, aclk, aresetn, start |=> busy_reg)
endmodule

FILE: rtl/lidar_pole_detector_top.sv
// Top level of the lidar pole detector: beam to point, clustering, pole ranking.
// Depends on lpd_pkg, lpd_isqrt and assert_macros.svh.
`include "assert_macros.svh"
// Each beam item is handled by a small sequencer over one shared 18x18 signed
// multiplier and one accumulator. A beam that gives no point goes straight to S_END;
// a point outside the map passes S_MUL_X, S_MUL_Y, S_PT_Y and S_CHECK; a kept point
// adds S_DX, S_DY, S_GAP and S_PLACE, and one that closes a cluster also S_CDX,
// S_CDY, the square root unit (17 root bits, one per cycle), S_ERR, S_RANK, S_CSUM.
// A scan end item closes any open cluster the same way, loads the result items if
// all POLE_COUNT slots are filled, waits on m_tready as needed and clears them.
// Results sit in an output register; the block takes no new item until they are delivered.
module lidar_pole_detector_top
    import lpd_pkg::*;
#(
    parameter int POLE_COUNT = PoleCount
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [47:0]         s_tdata,  // beam_range[14:0], dir_cos[30:15], dir_sin[46:31]
    input  logic                s_tuser,  // beam_valid
    input  logic                s_tlast,  // scan_end
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata,  // pole_x[15:0], pole_y[31:16]
    output logic                m_tuser,  // pole_slot
    output logic                m_tlast,  // last_pole
    input  logic                cfg_wr_en,
    input  logic [CfgAddrW-1:0] cfg_wr_addr,
    input  logic [CfgDataW-1:0] cfg_wr_data
);
    localparam int SlotW = (POLE_COUNT > 1) ? $clog2(POLE_COUNT) : 1;
    localparam int CntW  = $clog2(POLE_COUNT + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_MUL_X, S_MUL_Y, S_PT_X, S_PT_Y, S_CHECK, S_DX, S_DY, S_GAP,
        S_PLACE, S_END, S_CDX, S_CDY, S_CSUM, S_SQRT_GO, S_SQRT_WAIT, S_ERR,
        S_RANK, S_EMIT0, S_EMIT1, S_WAIT_OUT
    } state_t;

    // Configuration registers
    logic [14:0] min_range_reg;
    logic [23:0] gap_sq_reg, width_err_reg;
    logic [11:0] pole_width_reg;
    logic [15:0] extent_x_reg, extent_y_reg;
    logic signed [16:0] sensor_x_reg, sensor_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_range_reg  <= MinRangeReset;
            gap_sq_reg     <= GapSqReset;
            pole_width_reg <= PoleWidthReset;
            width_err_reg  <= WidthErrReset;
            extent_x_reg   <= ExtentReset;
            extent_y_reg   <= ExtentReset;
            sensor_x_reg   <= '0;
            sensor_y_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_wr_addr))
                REG_MIN_RANGE:    min_range_reg  <= cfg_wr_data[14:0];
                REG_GAP_SQ:       gap_sq_reg     <= cfg_wr_data;
                REG_POLE_WIDTH:   pole_width_reg <= cfg_wr_data[11:0];
                REG_WIDTH_ERR_SQ: width_err_reg  <= cfg_wr_data;
                REG_EXTENT_X:     extent_x_reg   <= cfg_wr_data[15:0];
                REG_EXTENT_Y:     extent_y_reg   <= cfg_wr_data[15:0];
                REG_SENSOR_X:     sensor_x_reg   <= cfg_wr_data[16:0];
                REG_SENSOR_Y:     sensor_y_reg   <= cfg_wr_data[16:0];
                default:          ;
            endcase
        end
    end

    state_t state_reg;
    logic [14:0] range_reg;
    logic signed [15:0] cos_reg, sin_reg;
    logic valid_reg, last_reg;
    logic signed [33:0] prod_reg;      // shared multiplier output
    logic signed [35:0] acc_reg;       // shared accumulator
    logic signed [18:0] px_reg, py_reg;
    logic [15:0] prev_x_reg, prev_y_reg, start_x_reg, start_y_reg;
    logic open_reg;
    logic [15:0] best_x_reg [POLE_COUNT];
    logic [15:0] best_y_reg [POLE_COUNT];
    logic [23:0] best_e_reg [POLE_COUNT];
    logic [CntW-1:0] count_reg;
    logic signed [17:0] dx_reg;
    logic [34:0] e2_reg;
    logic closing_end_reg;             // close was triggered by the scan end
    logic out_valid_reg, out_slot_reg, out_last_reg;
    logic [15:0] out_x_reg, out_y_reg;
    logic emit_more_reg;
    logic [SlotW-1:0] emit_idx_reg;

    // Shared multiplier operands
    logic signed [17:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [34:0] mul_p;
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_MUL_X: begin mul_a = 18'(signed'({1'b0, range_reg})); mul_b = 18'(cos_reg); end
            S_MUL_Y: begin mul_a = 18'(signed'({1'b0, range_reg})); mul_b = 18'(sin_reg); end
            S_DX, S_DY, S_CDX, S_CDY, S_RANK: begin mul_a = dx_reg; mul_b = dx_reg; end
            default: ;
        endcase
    end
    // Every squared operand stays below 2^17 in magnitude, so 35 bits hold the product.
    assign mul_p = 35'(mul_a * mul_b);

    // Rounding of a Q14 product, halves toward plus infinity.
    logic signed [34:0] rnd_t;
    logic signed [18:0] rnd_q;
    assign rnd_t = 35'(prod_reg) + 35'sd8192;
    assign rnd_q = 19'(rnd_t >>> 14);

    // Square root unit
    sqrt_ctl_t sq_ctl;
    logic [SqrtOutW-1:0] sq_root;
    logic sq_start;
    assign sq_start = (state_reg == S_SQRT_GO);
    lpd_isqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand (SqrtInW'(acc_reg)),
        .ctl      (sq_ctl),
        .root     (sq_root)
    );

    logic in_map;
    assign in_map = !px_reg[18] && (px_reg < 19'(signed'({3'b0, extent_x_reg})))
                 && !py_reg[18] && (py_reg < 19'(signed'({3'b0, extent_y_reg})));

    // Insertion position among the ranked candidates
    logic [CntW-1:0] pos;
    always_comb begin
        pos = count_reg;
        for (int i = POLE_COUNT - 1; i >= 0; i--) begin
            if (CntW'(i) < count_reg && e2_reg < 35'(best_e_reg[i])) pos = CntW'(i);
        end
    end

    logic y_equal, y_swap;
    assign y_equal = (POLE_COUNT == 2) && (best_y_reg[POLE_COUNT-1] == best_y_reg[0]);
    assign y_swap  = (POLE_COUNT == 2) && (best_y_reg[POLE_COUNT-1] < best_y_reg[0]);

    assign s_tready = (state_reg == S_IDLE) && !out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            open_reg      <= 1'b0;
            count_reg     <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            out_valid_reg <= 1'b0;
            emit_more_reg <= 1'b0;
        end else begin
            // The second result item reloads the register in S_EMIT1 instead.
            if (out_valid_reg && m_tready && !(state_reg == S_EMIT1 && emit_more_reg))
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: if (s_tvalid && s_tready) begin
                    range_reg <= s_tdata[14:0];
                    cos_reg   <= s_tdata[30:15];
                    sin_reg   <= s_tdata[46:31];
                    valid_reg <= s_tuser;
                    last_reg  <= s_tlast;
                    state_reg <= (s_tuser && s_tdata[14:0] >= min_range_reg) ? S_MUL_X : S_END;
                end
                S_MUL_X: begin prod_reg <= 34'(mul_p); state_reg <= S_MUL_Y; end
                S_MUL_Y: begin
                    px_reg    <= 19'(sensor_x_reg) + rnd_q;
                    prod_reg  <= 34'(mul_p);
                    state_reg <= S_PT_Y;
                end
                S_PT_Y: begin py_reg <= 19'(sensor_y_reg) + rnd_q; state_reg <= S_CHECK; end
                S_CHECK: begin
                    dx_reg    <= 18'(px_reg - 19'(signed'({3'b0, prev_x_reg})));
                    state_reg <= in_map ? S_DX : S_END;
                end
                S_DX: begin
                    acc_reg   <= 36'(mul_p);
                    dx_reg    <= 18'(py_reg - 19'(signed'({3'b0, prev_y_reg})));
                    state_reg <= S_DY;
                end
                S_DY: begin acc_reg <= acc_reg + 36'(mul_p); state_reg <= S_GAP; end
                S_GAP: begin
                    closing_end_reg <= 1'b0;
                    if (acc_reg > 36'(gap_sq_reg) && open_reg) begin
                        dx_reg    <= 18'({2'b0, start_x_reg}) - 18'({2'b0, prev_x_reg});
                        state_reg <= S_CDX;
                    end else state_reg <= S_PLACE;
                end
                S_PLACE: begin
                    if (!open_reg) begin
                        start_x_reg <= px_reg[15:0];
                        start_y_reg <= py_reg[15:0];
                        open_reg    <= 1'b1;
                    end
                    prev_x_reg <= px_reg[15:0];
                    prev_y_reg <= py_reg[15:0];
                    state_reg  <= S_END;
                end
                S_END: begin
                    if (!last_reg) state_reg <= S_IDLE;
                    else if (open_reg) begin
                        closing_end_reg <= 1'b1;
                        dx_reg    <= 18'({2'b0, start_x_reg}) - 18'({2'b0, prev_x_reg});
                        state_reg <= S_CDX;
                    end else state_reg <= S_EMIT0;
                end
                S_CDX: begin
                    acc_reg   <= 36'(mul_p);
                    dx_reg    <= 18'({2'b0, start_y_reg}) - 18'({2'b0, prev_y_reg});
                    state_reg <= S_CDY;
                end
                S_CDY: begin acc_reg <= acc_reg + 36'(mul_p); state_reg <= S_SQRT_GO; end
                S_SQRT_GO: state_reg <= S_SQRT_WAIT;
                S_SQRT_WAIT: if (sq_ctl.done) begin
                    dx_reg    <= 18'({1'b0, sq_root}) - 18'({6'b0, pole_width_reg});
                    state_reg <= S_ERR;
                end
                S_ERR: state_reg <= S_RANK;  // dx now holds the error; square it next
                S_RANK: begin
                    e2_reg    <= 35'(mul_p);
                    state_reg <= S_CSUM;
                end
                S_CSUM: begin
                    open_reg <= 1'b0;
                    if (e2_reg <= 35'(width_err_reg) && pos < CntW'(POLE_COUNT)) begin
                        for (int i = POLE_COUNT - 1; i > 0; i--) begin
                            if (CntW'(i) > pos) begin
                                best_x_reg[i] <= best_x_reg[i-1];
                                best_y_reg[i] <= best_y_reg[i-1];
                                best_e_reg[i] <= best_e_reg[i-1];
                            end
                        end
                        best_x_reg[pos[SlotW-1:0]] <= 16'((17'(start_x_reg) + 17'(prev_x_reg)) >> 1);
                        best_y_reg[pos[SlotW-1:0]] <= 16'((17'(start_y_reg) + 17'(prev_y_reg)) >> 1);
                        best_e_reg[pos[SlotW-1:0]] <= e2_reg[23:0];
                        if (count_reg < CntW'(POLE_COUNT)) count_reg <= count_reg + 1'b1;
                    end
                    state_reg <= closing_end_reg ? S_EMIT0 : S_PLACE;
                end
                S_EMIT0: begin
                    if (count_reg >= CntW'(POLE_COUNT)) begin
                        emit_idx_reg  <= (y_swap && !y_equal) ? SlotW'(0) : SlotW'(POLE_COUNT-1);
                        out_x_reg     <= best_x_reg[(y_swap && !y_equal) ?
                                                    SlotW'(POLE_COUNT-1) : SlotW'(0)];
                        out_y_reg     <= best_y_reg[(y_swap && !y_equal) ?
                                                    SlotW'(POLE_COUNT-1) : SlotW'(0)];
                        out_slot_reg  <= 1'b0;
                        out_last_reg  <= (POLE_COUNT == 1) || y_equal;
                        emit_more_reg <= (POLE_COUNT == 2) && !y_equal;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_EMIT1;
                    end else state_reg <= S_WAIT_OUT;
                end
                S_EMIT1: if (!out_valid_reg || m_tready) begin
                    if (emit_more_reg) begin
                        out_x_reg     <= best_x_reg[emit_idx_reg];
                        out_y_reg     <= best_y_reg[emit_idx_reg];
                        out_slot_reg  <= 1'b1;
                        out_last_reg  <= 1'b1;
                        out_valid_reg <= 1'b1;
                        emit_more_reg <= 1'b0;
                    end
                    state_reg <= S_WAIT_OUT;
                end
                S_WAIT_OUT: begin
                    open_reg   <= 1'b0;
                    count_reg  <= '0;
                    prev_x_reg <= '0;
                    prev_y_reg <= '0;
                    for (int i = 0; i < POLE_COUNT; i++) best_e_reg[i] <= '0;
                    state_reg  <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_y_reg, out_x_reg};
    assign m_tuser  = out_slot_reg;
    assign m_tlast  = out_last_reg;

    `ASSERT_CLK(a_busy_not_ready, aclk, aresetn, (state_reg != S_IDLE) |-> !s_tready)
    `ASSERT_CLK(a_count_range, aclk, aresetn, count_reg <= CntW'(POLE_COUNT))
    `ASSERT_CLK(a_sqrt_only_closing, aclk, aresetn, sq_ctl.busy |-> (state_reg == S_SQRT_WAIT))
    `ASSERT_CLK(a_slot1_last, aclk, aresetn, (m_tvalid && m_tuser) |-> m_tlast)
endmodule
